// ===== sv/utf8_validate_replace_top_assert.svh =====
// assertion macros for the utf8 validate and replace block
`ifndef UTF8_VALIDATE_REPLACE_TOP_ASSERT_SVH
`define UTF8_VALIDATE_REPLACE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define U8VR_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utf8 validate replace: check failed");

// next-cycle implication, checked out of reset
`define U8VR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utf8 validate replace: check failed");

`endif

// ===== sv/utf8vr_pkg.sv =====
// types and constants shared by the utf8 validate and replace block
package utf8vr_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       out_last;
  } out_t;

  localparam int NUM_UNITS = 4;

  // one output job: up to four units, each a byte or a replacement triple
  typedef struct packed {
    logic [NUM_UNITS-1:0][7:0] unit_byte;
    logic [NUM_UNITS-1:0]      unit_repl;
    logic [1:0]                last_unit;
    logic                      str_last;
  } job_t;

  typedef struct packed {
    logic       pending;
    logic [1:0] held_count;
    logic [2:0] seq_length;
  } front_stat_t;

  localparam logic [7:0] REPL_BYTE0 = 8'hEF;
  localparam logic [7:0] REPL_BYTE1 = 8'hBF;
  localparam logic [7:0] REPL_BYTE2 = 8'hBD;

  localparam logic [1:0] SUB_FIRST = 2'd0;
  localparam logic [1:0] SUB_MID   = 2'd1;
  localparam logic [1:0] SUB_FINAL = 2'd2;

  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  localparam logic [20:0] CP_MIN2   = 21'h000080;
  localparam logic [20:0] CP_MIN3   = 21'h000800;
  localparam logic [20:0] CP_MIN4   = 21'h010000;
  localparam logic [20:0] CP_MAX    = 21'h10FFFF;
  localparam logic [20:0] SURR_LO   = 21'h00D800;
  localparam logic [20:0] SURR_HI   = 21'h00DFFF;

endpackage

// ===== sv/utf8_validate_replace_top.sv =====
// top level of the streaming utf8 validate and replace block
//
// Takes a string one byte per beat (in_last on its final byte) and emits
// well-formed utf-8 one byte per beat. Ascii passes straight through; a
// multi-byte sequence is held in the front end until complete, then either
// emitted unchanged or, if overlong, a surrogate or above 0x10ffff, turned
// into one EF BF BD per sequence byte. A byte that breaks a sequence first
// flushes the held bytes as replacements and is then treated as if none were
// pending. run_last marks the last output beat caused by an input beat,
// out_last the final beat of the string. Rate: the back end sends one output
// beat per cycle while a job is queued and out_ready allows; an input beat
// causes 1 output beat for a passed byte, 3 for a replacement, up to 12 for a
// failed 4-byte sequence; held bytes cause none until their sequence resolves.
// The front end accepts one beat per cycle while the two-entry job queue has
// room; the output register loads a new byte in the cycle the old one is taken.
module utf8_validate_replace_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  utf8vr_pkg::in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output utf8vr_pkg::out_t out_data
);

`include "utf8_validate_replace_top_assert.svh"

  // front end to queue
  logic                    push_valid;
  logic                    push_ready;
  utf8vr_pkg::job_t        push_job;
  utf8vr_pkg::front_stat_t fstat;

  // queue to back end
  logic             head_valid;
  logic             pop;
  utf8vr_pkg::job_t head_job;

  // shape of a pending sequence, for the checks below
  logic pend_shape_ok;

  // classify bytes, track the pending sequence
  utf8vr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .job        (push_job),
    .stat       (fstat)
  );

  // decouples the one-beat-per-byte front from the multi-beat back
  utf8vr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .head_valid (head_valid),
    .pop        (pop),
    .head_job   (head_job)
  );

  // expand jobs into output beats
  utf8vr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign pend_shape_ok = (fstat.seq_length >= utf8vr_pkg::SEQ_LEN2) &&
                         (3'(fstat.held_count) < fstat.seq_length);

  // a pending sequence always has a real length and fewer held bytes than that
  `U8VR_ASSERT_IMPLIES(a_pending_shape, fstat.pending, pend_shape_ok)

  // a final beat always produces a job
  `U8VR_ASSERT_IMPLIES(a_last_emits, in_valid && in_ready && in_data.in_last, push_valid)

  // nothing stays pending past the end of a string
  `U8VR_ASSERT_NEXT(a_last_clears, in_valid && in_ready && in_data.in_last, !fstat.pending)

endmodule

// ===== sv/utf8vr_front.sv =====
// front end: classifies each input byte against the pending sequence and builds output jobs
module utf8vr_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  utf8vr_pkg::in_t        in_data,
  output logic                   push_valid,
  input  logic                   push_ready,
  output utf8vr_pkg::job_t       job,
  output utf8vr_pkg::front_stat_t stat
);

  logic [2:0][7:0] held_bytes;
  logic [2:0]      seq_length;
  logic [1:0]      held_count;
  logic [20:0]     code_point;

  logic [7:0]  b;
  logic        last;
  logic        accept;
  logic        pending;
  logic        is_cont;
  logic [2:0]  lead_len;
  logic [20:0] lead_init;
  logic        start_hold;
  logic        start_repl;
  logic [20:0] cp;
  logic        complete;
  logic        bad;
  logic        emit_held;
  logic        held_repl;
  logic        new_unit;
  logic        new_repl;
  logic [2:0]  n_held;
  logic [2:0]  n_total;

  assign b        = in_data.in_byte;
  assign last     = in_data.in_last;
  assign accept   = in_valid && push_ready;
  assign in_ready = push_ready;
  assign pending  = (seq_length != utf8vr_pkg::SEQ_NONE);
  assign is_cont  = (b[7:6] == 2'b10);
  assign cp       = {code_point[14:0], b[5:0]};

  // lead byte decode
  always_comb begin
    lead_len  = utf8vr_pkg::SEQ_NONE;
    lead_init = '0;
    priority if (b[7:5] == 3'b110) begin
      lead_len  = utf8vr_pkg::SEQ_LEN2;
      lead_init = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      lead_len  = utf8vr_pkg::SEQ_LEN3;
      lead_init = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      lead_len  = utf8vr_pkg::SEQ_LEN4;
      lead_init = {18'd0, b[2:0]};
    end else begin
      lead_len  = utf8vr_pkg::SEQ_NONE;
      lead_init = '0;
    end
  end

  assign start_hold = (lead_len != utf8vr_pkg::SEQ_NONE) && !last;
  assign start_repl = b[7];
  assign complete   = pending && is_cont && (({1'b0, held_count} + 3'd1) >= seq_length);

  always_comb begin
    bad = (cp > utf8vr_pkg::CP_MAX) ||
          ((cp >= utf8vr_pkg::SURR_LO) && (cp <= utf8vr_pkg::SURR_HI));
    unique case (seq_length)
      utf8vr_pkg::SEQ_LEN2: bad = bad || (cp < utf8vr_pkg::CP_MIN2);
      utf8vr_pkg::SEQ_LEN3: bad = bad || (cp < utf8vr_pkg::CP_MIN3);
      utf8vr_pkg::SEQ_LEN4: bad = bad || (cp < utf8vr_pkg::CP_MIN4);
      default:              bad = bad;
    endcase
  end

  // which units this byte emits
  always_comb begin
    if (!pending) begin
      emit_held = 1'b0;
      held_repl = 1'b0;
      new_unit  = !start_hold;
      new_repl  = start_repl;
    end else if (is_cont) begin
      emit_held = complete || last;
      held_repl = complete ? bad : 1'b1;
      new_unit  = complete || last;
      new_repl  = complete ? bad : 1'b1;
    end else begin
      emit_held = 1'b1;
      held_repl = 1'b1;
      new_unit  = !start_hold;
      new_repl  = start_repl;
    end
  end

  assign n_held  = emit_held ? {1'b0, held_count} : 3'd0;
  assign n_total = n_held + {2'd0, new_unit};

  always_comb begin
    for (int i = 0; i < utf8vr_pkg::NUM_UNITS; i++) begin
      if ((i < 3) && (3'(i) < n_held)) begin
        job.unit_byte[i] = held_bytes[i[1:0]];
        job.unit_repl[i] = held_repl;
      end else begin
        job.unit_byte[i] = b;
        job.unit_repl[i] = new_repl;
      end
    end
    job.last_unit = 2'(n_total - 3'd1);
    job.str_last  = last;
  end

  assign push_valid = in_valid && (n_total != 3'd0);

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_length <= utf8vr_pkg::SEQ_NONE;
      held_count <= 2'd0;
      code_point <= '0;
    end else if (accept) begin
      if (!pending || !is_cont) begin
        if (start_hold) begin
          seq_length <= lead_len;
          held_count <= 2'd1;
          code_point <= lead_init;
        end else begin
          seq_length <= utf8vr_pkg::SEQ_NONE;
          held_count <= 2'd0;
          code_point <= '0;
        end
      end else if (complete || last) begin
        seq_length <= utf8vr_pkg::SEQ_NONE;
        held_count <= 2'd0;
        code_point <= '0;
      end else begin
        held_count <= held_count + 2'd1;
        code_point <= cp;
      end
    end
  end

  // held byte storage, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      if (!pending || !is_cont) begin
        if (start_hold) begin
          held_bytes[0] <= b;
        end
      end else if (!(complete || last)) begin
        held_bytes[held_count] <= b;
      end
    end
  end

  assign stat.pending    = pending;
  assign stat.held_count = held_count;
  assign stat.seq_length = seq_length;

endmodule

// ===== sv/utf8vr_queue.sv =====
// two-entry job queue between front and back
module utf8vr_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  utf8vr_pkg::job_t push_job,
  output logic             head_valid,
  input  logic             pop,
  output utf8vr_pkg::job_t head_job
);

  utf8vr_pkg::job_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;

  assign push_ready = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_job   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== sv/utf8vr_back.sv =====
// back end: expands queued jobs into output bytes through an output register
module utf8vr_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  utf8vr_pkg::job_t head_job,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output utf8vr_pkg::out_t out_data
);

  logic [1:0] unit_idx;
  logic [1:0] sub_idx;
  logic       advance;
  logic       cur_repl;
  logic [7:0] cur_byte;
  logic       unit_done;
  logic       job_done;

  assign advance  = head_valid && (!out_valid || out_ready);
  assign cur_repl = head_job.unit_repl[unit_idx];

  always_comb begin
    if (cur_repl) begin
      unique case (sub_idx)
        utf8vr_pkg::SUB_FIRST: cur_byte = utf8vr_pkg::REPL_BYTE0;
        utf8vr_pkg::SUB_MID:   cur_byte = utf8vr_pkg::REPL_BYTE1;
        default:               cur_byte = utf8vr_pkg::REPL_BYTE2;
      endcase
    end else begin
      cur_byte = head_job.unit_byte[unit_idx];
    end
  end

  assign unit_done = !cur_repl || (sub_idx == utf8vr_pkg::SUB_FINAL);
  assign job_done  = unit_done && (unit_idx == head_job.last_unit);
  assign pop       = advance && job_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_idx  <= 2'd0;
      sub_idx   <= utf8vr_pkg::SUB_FIRST;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        if (job_done) begin
          unit_idx <= 2'd0;
          sub_idx  <= utf8vr_pkg::SUB_FIRST;
        end else if (unit_done) begin
          unit_idx <= unit_idx + 2'd1;
          sub_idx  <= utf8vr_pkg::SUB_FIRST;
        end else begin
          sub_idx <= sub_idx + 2'd1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.out_byte <= cur_byte;
      out_data.run_last <= job_done;
      out_data.out_last <= job_done && head_job.str_last;
    end
  end

endmodule
